>>> rtl/core/shl2_pkg.sv
// Shared constants, types and the sequencer microprogram of the SH lighting evaluator.
package shl2_pkg;

  localparam int COEF_COUNT = 9;
  localparam int CH         = 3;
  localparam int IDX_W      = 4;
  localparam int DIR_W      = 16;
  localparam int DP_W       = 18;
  localparam int TERM_W     = 19;
  localparam int WT_W       = 19;
  localparam int KON_W      = 17;
  localparam int MUL_B_W    = 19;
  localparam int ACC_GUARD  = 7;
  localparam int PC_W       = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ONE_Q14 = 16384;
  localparam int HALF_14 = 8192;
  localparam int HALF_16 = 32768;

  // Q1.16 basis and convolution constants.
  localparam logic [KON_W-1:0] K_Y00    = 17'd18487;
  localparam logic [KON_W-1:0] K_Y1     = 17'd32021;
  localparam logic [KON_W-1:0] K_Y2A    = 17'd71601;
  localparam logic [KON_W-1:0] K_Y20    = 17'd20670;
  localparam logic [KON_W-1:0] K_Y22    = 17'd35801;
  localparam logic [KON_W-1:0] K_C1     = 17'd28118;
  localparam logic [KON_W-1:0] K_C1X2   = 17'd56236;
  localparam logic [KON_W-1:0] K_C2X2   = 17'd67064;
  localparam logic [KON_W-1:0] K_C3     = 17'd48701;
  localparam logic [KON_W-1:0] K_C4     = 17'd58080;
  localparam logic [KON_W-1:0] K_INV_PI = 17'd20861;

  // C5 times one in Q.14, subtracted before rounding the irradiance zonal weight.
  localparam int C5_ONE = 16234 * 16384;

  // Basis index whose irradiance weight carries the constant offset.
  localparam logic [IDX_W-1:0] IDX_ZONAL = 4'd6;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  localparam logic [1:0] MODE_RADIANCE   = 2'd0;
  localparam logic [1:0] MODE_IRRADIANCE = 2'd1;
  localparam logic [1:0] MODE_AMBIENT    = 2'd2;

  localparam logic [CFG_ADDR_W-3:0] REG_EVAL_MODE = 1'b0;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    UOP_DIRSQ,
    UOP_DIRX,
    UOP_WEIGHT,
    UOP_MAC,
    UOP_SCALE,
    UOP_DONE
  } uop_t;

  typedef enum logic {
    JMP_NEXT,
    JMP_IF_NOT_AMBIENT
  } jmp_t;

  typedef struct packed {
    uop_t            op;
    logic [IDX_W-1:0] idx;
    logic            clr;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_DONE = 4'd15;

  function automatic logic [KON_W-1:0] basis_const(input logic [IDX_W-1:0] k,
                                                   input logic irr);
    logic [KON_W-1:0] kc;
    case (k)
      4'd0:    kc = irr ? K_C4   : K_Y00;
      4'd1:    kc = irr ? K_C2X2 : K_Y1;
      4'd2:    kc = irr ? K_C2X2 : K_Y1;
      4'd3:    kc = irr ? K_C2X2 : K_Y1;
      4'd4:    kc = irr ? K_C1X2 : K_Y2A;
      4'd5:    kc = irr ? K_C1X2 : K_Y2A;
      4'd6:    kc = irr ? K_C3   : K_Y20;
      4'd7:    kc = irr ? K_C1X2 : K_Y2A;
      4'd8:    kc = irr ? K_C1   : K_Y22;
      default: kc = '0;
    endcase
    return kc;
  endfunction

  // The evaluation program: direction products, weights three at a time,
  // nine multiply-accumulate steps, optional 1/pi scaling, then the result.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = '{op: UOP_DONE, idx: '0, clr: 1'b0, jmp: JMP_NEXT, target: '0};
    case (pc)
      4'd0:  u.op = UOP_DIRSQ;
      4'd1:  u.op = UOP_DIRX;
      4'd2:  begin u.op = UOP_WEIGHT; u.idx = 4'd0; end
      4'd3:  begin u.op = UOP_WEIGHT; u.idx = 4'd3; end
      4'd4:  begin u.op = UOP_WEIGHT; u.idx = 4'd6; end
      4'd5:  begin u.op = UOP_MAC; u.idx = 4'd0; u.clr = 1'b1; end
      4'd6:  begin u.op = UOP_MAC; u.idx = 4'd1; end
      4'd7:  begin u.op = UOP_MAC; u.idx = 4'd2; end
      4'd8:  begin u.op = UOP_MAC; u.idx = 4'd3; end
      4'd9:  begin u.op = UOP_MAC; u.idx = 4'd4; end
      4'd10: begin u.op = UOP_MAC; u.idx = 4'd5; end
      4'd11: begin u.op = UOP_MAC; u.idx = 4'd6; end
      4'd12: begin u.op = UOP_MAC; u.idx = 4'd7; end
      4'd13: begin
        u.op     = UOP_MAC;
        u.idx    = 4'd8;
        u.jmp    = JMP_IF_NOT_AMBIENT;
        u.target = PC_DONE;
      end
      4'd14: u.op = UOP_SCALE;
      4'd15: u.op = UOP_DONE;
      default: u.op = UOP_DONE;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/shl2_if.sv
// Command and result channel interfaces of the SH lighting evaluator.
interface shl2_cmd_if #(
  parameter int COEFF_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [shl2_pkg::IDX_W-1:0]    coef_index;
  logic signed [COEFF_WIDTH-1:0] coef_red;
  logic signed [COEFF_WIDTH-1:0] coef_green;
  logic signed [COEFF_WIDTH-1:0] coef_blue;
  logic signed [shl2_pkg::DIR_W-1:0] dir_x;
  logic signed [shl2_pkg::DIR_W-1:0] dir_y;
  logic signed [shl2_pkg::DIR_W-1:0] dir_z;

  modport source (
    output valid, kind, coef_index, coef_red, coef_green, coef_blue, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, kind, coef_index, coef_red, coef_green, coef_blue, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

interface shl2_res_if #(
  parameter int COEFF_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COEFF_WIDTH-1:0] out_red;
  logic signed [COEFF_WIDTH-1:0] out_green;
  logic signed [COEFF_WIDTH-1:0] out_blue;
  logic                          saturated;

  modport source (
    output valid, out_red, out_green, out_blue, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, saturated,
    output ready
  );
endinterface

>>> rtl/core/sh_l2_radiance_irradiance_eval_unit.sv
// Order-2 spherical-harmonic lighting evaluator: nine RGB coefficients and a
// direction give radiance, irradiance or irradiance over pi in fixed point.
// A write word on cmd loads one coefficient triple (indexes above eight are
// dropped). An evaluate word runs a 16-step microprogram on three
// multipliers, one per color channel: six direction products, nine basis
// weights, nine multiply-accumulate steps, an optional 1/pi scaling and the
// saturating output step. No new word is taken while an evaluation runs.
// The result sits in an output register, so new words are taken while it
// waits; a second evaluation stalls in its last step until that register is
// free. The coefficient store clears at reset with no extra pass. Write
// eval_mode only while the block is idle; mode 3 evaluates as radiance.
module sh_l2_radiance_irradiance_eval_unit #(
  parameter int COEFF_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  shl2_cmd_if.sink                            cmd,
  shl2_res_if.source                          res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [shl2_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [shl2_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [shl2_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CW = COEFF_WIDTH;
  localparam int AW = CW + shl2_pkg::ACC_GUARD;
  localparam int PW = AW + shl2_pkg::MUL_B_W;
  localparam int NC = shl2_pkg::COEF_COUNT;
  localparam int NL = shl2_pkg::CH;

  // Configuration.
  logic [1:0] eval_mode;
  logic       irr;
  logic       amb;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[shl2_pkg::CFG_ADDR_W-1:2] == shl2_pkg::REG_EVAL_MODE);
  assign prdata  = cfg_hit ? shl2_pkg::CFG_DATA_W'(eval_mode) : '0;
  assign irr     = (eval_mode == shl2_pkg::MODE_IRRADIANCE) ||
                   (eval_mode == shl2_pkg::MODE_AMBIENT);
  assign amb     = (eval_mode == shl2_pkg::MODE_AMBIENT);

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_mode <= shl2_pkg::MODE_IRRADIANCE;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      eval_mode <= pwdata[1:0];
    end
  end

  // Sequencer.
  shl2_pkg::seq_state_t      state, state_next;
  logic [shl2_pkg::PC_W-1:0] pc, pc_next;
  shl2_pkg::ucode_t          uc;
  logic                      cmd_ready;
  logic                      run;
  logic                      cmd_fire;
  logic                      eval_fire;
  logic                      done_fire;
  logic                      res_valid;

  assign uc        = shl2_pkg::ucode_rom(pc);
  assign cmd_fire  = cmd.valid && cmd_ready;
  assign eval_fire = cmd_fire && (cmd.kind == shl2_pkg::KIND_EVAL);
  assign done_fire = run && (uc.op == shl2_pkg::UOP_DONE) && (!res_valid || res.ready);
  assign cmd.ready = cmd_ready;

  always_comb begin
    pc_next = pc + 1'b1;
    if ((uc.jmp == shl2_pkg::JMP_IF_NOT_AMBIENT) && !amb) begin
      pc_next = uc.target;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      shl2_pkg::SEQ_IDLE: begin
        if (eval_fire) state_next = shl2_pkg::SEQ_RUN;
      end
      shl2_pkg::SEQ_RUN: begin
        if (done_fire) state_next = shl2_pkg::SEQ_IDLE;
      end
      default: state_next = shl2_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    run       = 1'b0;
    case (state)
      shl2_pkg::SEQ_IDLE: cmd_ready = 1'b1;
      shl2_pkg::SEQ_RUN:  run = 1'b1;
      default: begin
        cmd_ready = 1'b0;
        run       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shl2_pkg::SEQ_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      if (eval_fire) begin
        pc <= '0;
      end else if (run && (uc.op != shl2_pkg::UOP_DONE)) begin
        pc <= pc_next;
      end
    end
  end

  // Coefficient store, cleared at reset.
  logic signed [CW-1:0] coef_store [NC][NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        for (int j = 0; j < NL; j++) begin
          coef_store[i][j] <= '0;
        end
      end
    end else if (cmd_fire && (cmd.kind == shl2_pkg::KIND_WRITE) &&
                 (cmd.coef_index < shl2_pkg::IDX_W'(NC))) begin
      coef_store[cmd.coef_index][0] <= cmd.coef_red;
      coef_store[cmd.coef_index][1] <= cmd.coef_green;
      coef_store[cmd.coef_index][2] <= cmd.coef_blue;
    end
  end

  // Datapath registers.
  logic signed [shl2_pkg::DIR_W-1:0]  dir_v [NL];
  logic signed [shl2_pkg::DP_W-1:0]   pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [shl2_pkg::WT_W-1:0]   wt [NC];
  logic signed [AW-1:0]               acc [NL];

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      dir_v[0] <= cmd.dir_x;
      dir_v[1] <= cmd.dir_y;
      dir_v[2] <= cmd.dir_z;
    end
  end

  // Lane operand selection, multiply and rounding.
  logic signed [shl2_pkg::TERM_W-1:0]  zonal_rad;
  logic signed [shl2_pkg::TERM_W-1:0]  xx_my;
  logic [shl2_pkg::IDX_W-1:0]          wk [NL];
  logic signed [shl2_pkg::TERM_W-1:0]  term [NL];
  logic signed [AW-1:0]                mul_a [NL];
  logic signed [shl2_pkg::MUL_B_W-1:0] mul_b [NL];
  logic signed [PW-1:0]                mul_p [NL];
  logic signed [PW-1:0]                off [NL];
  logic signed [PW-1:0]                rsum [NL];
  logic signed [PW-1:0]                rnd_q [NL];
  logic                                sh16;

  assign zonal_rad = (shl2_pkg::TERM_W'(pzz) <<< 1) + shl2_pkg::TERM_W'(pzz) -
                     shl2_pkg::TERM_W'(shl2_pkg::ONE_Q14);
  assign xx_my     = shl2_pkg::TERM_W'(pxx) - shl2_pkg::TERM_W'(pyy);
  assign sh16      = (uc.op == shl2_pkg::UOP_WEIGHT) || (uc.op == shl2_pkg::UOP_SCALE);

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      wk[j] = uc.idx + shl2_pkg::IDX_W'(j);
      case (wk[j])
        4'd0:    term[j] = shl2_pkg::TERM_W'(shl2_pkg::ONE_Q14);
        4'd1:    term[j] = shl2_pkg::TERM_W'(dir_v[1]);
        4'd2:    term[j] = shl2_pkg::TERM_W'(dir_v[2]);
        4'd3:    term[j] = shl2_pkg::TERM_W'(dir_v[0]);
        4'd4:    term[j] = shl2_pkg::TERM_W'(pxy);
        4'd5:    term[j] = shl2_pkg::TERM_W'(pyz);
        4'd6:    term[j] = irr ? shl2_pkg::TERM_W'(pzz) : zonal_rad;
        4'd7:    term[j] = shl2_pkg::TERM_W'(pxz);
        4'd8:    term[j] = xx_my;
        default: term[j] = '0;
      endcase

      mul_a[j] = '0;
      mul_b[j] = '0;
      off[j]   = '0;
      case (uc.op)
        shl2_pkg::UOP_DIRSQ: begin
          mul_a[j] = AW'(dir_v[j]);
          mul_b[j] = shl2_pkg::MUL_B_W'(dir_v[j]);
        end
        shl2_pkg::UOP_DIRX: begin
          // Lanes form xy, xz and yz.
          mul_a[j] = (j == 2) ? AW'(dir_v[1]) : AW'(dir_v[0]);
          mul_b[j] = (j == 0) ? shl2_pkg::MUL_B_W'(dir_v[1])
                              : shl2_pkg::MUL_B_W'(dir_v[2]);
        end
        shl2_pkg::UOP_WEIGHT: begin
          mul_a[j] = AW'(term[j]);
          mul_b[j] = shl2_pkg::MUL_B_W'($signed({1'b0, shl2_pkg::basis_const(wk[j], irr)}));
          if (irr && (wk[j] == shl2_pkg::IDX_ZONAL)) begin
            off[j] = PW'(shl2_pkg::C5_ONE);
          end
        end
        shl2_pkg::UOP_MAC: begin
          mul_a[j] = AW'(coef_store[uc.idx][j]);
          mul_b[j] = wt[uc.idx];
        end
        shl2_pkg::UOP_SCALE: begin
          mul_a[j] = acc[j];
          mul_b[j] = shl2_pkg::MUL_B_W'($signed({1'b0, shl2_pkg::K_INV_PI}));
        end
        default: begin
          mul_a[j] = '0;
          mul_b[j] = '0;
        end
      endcase

      mul_p[j] = mul_a[j] * mul_b[j];
      rsum[j]  = mul_p[j] - off[j] +
                 (sh16 ? PW'(shl2_pkg::HALF_16) : PW'(shl2_pkg::HALF_14));
      rnd_q[j] = sh16 ? (rsum[j] >>> 16) : (rsum[j] >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      case (uc.op)
        shl2_pkg::UOP_DIRSQ: begin
          pxx <= rnd_q[0][shl2_pkg::DP_W-1:0];
          pyy <= rnd_q[1][shl2_pkg::DP_W-1:0];
          pzz <= rnd_q[2][shl2_pkg::DP_W-1:0];
        end
        shl2_pkg::UOP_DIRX: begin
          pxy <= rnd_q[0][shl2_pkg::DP_W-1:0];
          pxz <= rnd_q[1][shl2_pkg::DP_W-1:0];
          pyz <= rnd_q[2][shl2_pkg::DP_W-1:0];
        end
        shl2_pkg::UOP_WEIGHT: begin
          for (int j = 0; j < NL; j++) begin
            wt[wk[j]] <= rnd_q[j][shl2_pkg::WT_W-1:0];
          end
        end
        shl2_pkg::UOP_MAC: begin
          for (int j = 0; j < NL; j++) begin
            acc[j] <= (uc.clr ? AW'(0) : acc[j]) + $signed(rnd_q[j][AW-1:0]);
          end
        end
        shl2_pkg::UOP_SCALE: begin
          for (int j = 0; j < NL; j++) begin
            acc[j] <= $signed(rnd_q[j][AW-1:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Saturation and the output register.
  logic                 in_rng [NL];
  logic signed [CW-1:0] sat_val [NL];
  logic                 any_clip;

  always_comb begin
    any_clip = 1'b0;
    for (int j = 0; j < NL; j++) begin
      in_rng[j] = (&acc[j][AW-1:CW-1]) || !(|acc[j][AW-1:CW-1]);
      if (in_rng[j]) begin
        sat_val[j] = acc[j][CW-1:0];
      end else if (acc[j][AW-1]) begin
        sat_val[j] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat_val[j] = {1'b0, {(CW-1){1'b1}}};
      end
      any_clip = any_clip || !in_rng[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      res.out_red   <= sat_val[0];
      res.out_green <= sat_val[1];
      res.out_blue  <= sat_val[2];
      res.saturated <= any_clip;
    end
  end

  assign res.valid = res_valid;

endmodule

>>> bench/tb_sh_l2_radiance_irradiance_eval_unit.sv
// Self-checking bench for the order-2 SH lighting evaluator: loads, evaluations, mode register.
`timescale 1ns / 100ps

module tb_sh_l2_radiance_irradiance_eval_unit;

  localparam int CW            = 24;
  localparam int SETTLE_CYCLES = 24;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [shl2_pkg::CFG_ADDR_W-3:0] REG_UNMAPPED = 1'b1;
  localparam logic [shl2_pkg::CFG_ADDR_W-1:0] ADDR_EVAL_MODE =
    {shl2_pkg::REG_EVAL_MODE, 2'b00};
  localparam logic [shl2_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED  = {REG_UNMAPPED, 2'b00};

  typedef struct packed {
    logic                              kind;
    logic [shl2_pkg::IDX_W-1:0]        coef_index;
    logic signed [CW-1:0]              coef_red;
    logic signed [CW-1:0]              coef_green;
    logic signed [CW-1:0]              coef_blue;
    logic signed [shl2_pkg::DIR_W-1:0] dir_x;
    logic signed [shl2_pkg::DIR_W-1:0] dir_y;
    logic signed [shl2_pkg::DIR_W-1:0] dir_z;
  } cmd_word_t;

  typedef struct packed {
    logic signed [CW-1:0] out_red;
    logic signed [CW-1:0] out_green;
    logic signed [CW-1:0] out_blue;
    logic                 saturated;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [shl2_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [shl2_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [shl2_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  shl2_cmd_if #(.COEFF_WIDTH(CW)) cmd_ch ();
  shl2_res_if #(.COEFF_WIDTH(CW)) res_ch ();

  sh_l2_radiance_irradiance_eval_unit #(.COEFF_WIDTH(CW)) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state.
  longint     coef_store [shl2_pkg::COEF_COUNT][shl2_pkg::CH];
  logic [1:0] mode_shadow = shl2_pkg::MODE_IRRADIANCE;

  cmd_word_t cmd_backlog [$];
  color_t    expected_colors [$];
  int        words_queued   = 0;
  int        words_accepted = 0;
  int        mismatches     = 0;

  cmd_word_t   on_bus;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  color_t      want;

  initial begin
    for (int i = 0; i < shl2_pkg::COEF_COUNT; i++)
      for (int c = 0; c < shl2_pkg::CH; c++)
        coef_store[i][c] = 0;
  end

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint scale_q16(input longint k, input longint t);
    return round_shift(k * t, 16);
  endfunction

  function automatic color_t shade_direction(input logic signed [shl2_pkg::DIR_W-1:0] dx,
                                             input logic signed [shl2_pkg::DIR_W-1:0] dy,
                                             input logic signed [shl2_pkg::DIR_W-1:0] dz);
    longint x, y, z, xx, yy, zz, xy, xz, yz, acc, hi, lo;
    longint basis [shl2_pkg::COEF_COUNT];
    logic signed [CW-1:0] chan [shl2_pkg::CH];
    color_t col;
    x  = dx;
    y  = dy;
    z  = dz;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -(longint'(1) <<< (CW - 1));
    xx = round_shift(x * x, 14);
    yy = round_shift(y * y, 14);
    zz = round_shift(z * z, 14);
    xy = round_shift(x * y, 14);
    xz = round_shift(x * z, 14);
    yz = round_shift(y * z, 14);
    if (mode_shadow == shl2_pkg::MODE_IRRADIANCE || mode_shadow == shl2_pkg::MODE_AMBIENT) begin
      basis[0] = scale_q16(shl2_pkg::K_C4, shl2_pkg::ONE_Q14);
      basis[1] = scale_q16(shl2_pkg::K_C2X2, y);
      basis[2] = scale_q16(shl2_pkg::K_C2X2, z);
      basis[3] = scale_q16(shl2_pkg::K_C2X2, x);
      basis[4] = scale_q16(shl2_pkg::K_C1X2, xy);
      basis[5] = scale_q16(shl2_pkg::K_C1X2, yz);
      // The zonal term carries a constant offset that is removed before rounding.
      basis[6] = round_shift(longint'(shl2_pkg::K_C3) * zz - longint'(shl2_pkg::C5_ONE), 16);
      basis[7] = scale_q16(shl2_pkg::K_C1X2, xz);
      basis[8] = scale_q16(shl2_pkg::K_C1, xx - yy);
    end else begin
      basis[0] = scale_q16(shl2_pkg::K_Y00, shl2_pkg::ONE_Q14);
      basis[1] = scale_q16(shl2_pkg::K_Y1, y);
      basis[2] = scale_q16(shl2_pkg::K_Y1, z);
      basis[3] = scale_q16(shl2_pkg::K_Y1, x);
      basis[4] = scale_q16(shl2_pkg::K_Y2A, xy);
      basis[5] = scale_q16(shl2_pkg::K_Y2A, yz);
      basis[6] = scale_q16(shl2_pkg::K_Y20, 3 * zz - shl2_pkg::ONE_Q14);
      basis[7] = scale_q16(shl2_pkg::K_Y2A, xz);
      basis[8] = scale_q16(shl2_pkg::K_Y22, xx - yy);
    end
    col.saturated = 1'b0;
    for (int c = 0; c < shl2_pkg::CH; c++) begin
      acc = 0;
      for (int i = 0; i < shl2_pkg::COEF_COUNT; i++)
        acc += round_shift(coef_store[i][c] * basis[i], 14);
      if (mode_shadow == shl2_pkg::MODE_AMBIENT)
        acc = scale_q16(shl2_pkg::K_INV_PI, acc);
      if (acc > hi) begin
        acc = hi;
        col.saturated = 1'b1;
      end
      if (acc < lo) begin
        acc = lo;
        col.saturated = 1'b1;
      end
      chan[c] = CW'(acc);
    end
    col.out_red   = chan[0];
    col.out_green = chan[1];
    col.out_blue  = chan[2];
    return col;
  endfunction

  // Loads update the shadow store; evaluations queue the color they must produce.
  function automatic void load_or_shade(input cmd_word_t w);
    if (w.kind == shl2_pkg::KIND_WRITE) begin
      if (w.coef_index < shl2_pkg::COEF_COUNT) begin
        coef_store[w.coef_index][0] = w.coef_red;
        coef_store[w.coef_index][1] = w.coef_green;
        coef_store[w.coef_index][2] = w.coef_blue;
      end
    end else begin
      expected_colors.push_back(shade_direction(w.dir_x, w.dir_y, w.dir_z));
    end
  endfunction

  function automatic int unsigned draw_gap(inout bit steady);
    if ($urandom_range(0, 39) == 0)
      steady = !steady;
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic signed [CW-1:0] random_coef();
    case ($urandom_range(0, 7))
      0: return CW'($urandom);
      1: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic cmd_word_t load_word(input int idx, input int r, input int g,
                                          input int b);
    cmd_word_t w;
    w.kind       = shl2_pkg::KIND_WRITE;
    w.coef_index = shl2_pkg::IDX_W'(idx);
    w.coef_red   = CW'(r);
    w.coef_green = CW'(g);
    w.coef_blue  = CW'(b);
    w.dir_x      = shl2_pkg::DIR_W'($urandom);
    w.dir_y      = shl2_pkg::DIR_W'($urandom);
    w.dir_z      = shl2_pkg::DIR_W'($urandom);
    return w;
  endfunction

  function automatic cmd_word_t eval_word(input int x, input int y, input int z);
    cmd_word_t w;
    w.kind       = shl2_pkg::KIND_EVAL;
    w.coef_index = shl2_pkg::IDX_W'($urandom);
    w.coef_red   = CW'($urandom);
    w.coef_green = CW'($urandom);
    w.coef_blue  = CW'($urandom);
    w.dir_x      = shl2_pkg::DIR_W'(x);
    w.dir_y      = shl2_pkg::DIR_W'(y);
    w.dir_z      = shl2_pkg::DIR_W'(z);
    return w;
  endfunction

  function automatic void push_word(input cmd_word_t w);
    cmd_backlog.push_back(w);
    words_queued++;
  endfunction

  // Command driver.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        load_or_shade(on_bus);
        words_accepted++;
        tx_wait = draw_gap(tx_steady);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (tx_wait == 0 && cmd_backlog.size() != 0) begin
          on_bus = cmd_backlog.pop_front();
          cmd_ch.valid      <= 1'b1;
          cmd_ch.kind       <= on_bus.kind;
          cmd_ch.coef_index <= on_bus.coef_index;
          cmd_ch.coef_red   <= on_bus.coef_red;
          cmd_ch.coef_green <= on_bus.coef_green;
          cmd_ch.coef_blue  <= on_bus.coef_blue;
          cmd_ch.dir_x      <= on_bus.dir_x;
          cmd_ch.dir_y      <= on_bus.dir_y;
          cmd_ch.dir_z      <= on_bus.dir_z;
        end else begin
          if (tx_wait != 0)
            tx_wait--;
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_colors.size() == 0) begin
          $error("result word with none expected: out_red %0d out_green %0d out_blue %0d",
                 res_ch.out_red, res_ch.out_green, res_ch.out_blue);
          mismatches++;
        end else begin
          want = expected_colors.pop_front();
          if (res_ch.out_red !== want.out_red) begin
            $error("out_red expected %0d got %0d", want.out_red, res_ch.out_red);
            mismatches++;
          end
          if (res_ch.out_green !== want.out_green) begin
            $error("out_green expected %0d got %0d", want.out_green, res_ch.out_green);
            mismatches++;
          end
          if (res_ch.out_blue !== want.out_blue) begin
            $error("out_blue expected %0d got %0d", want.out_blue, res_ch.out_blue);
            mismatches++;
          end
          if (res_ch.saturated !== want.saturated) begin
            $error("saturated expected %0d got %0d", want.saturated, res_ch.saturated);
            mismatches++;
          end
        end
        rx_wait = draw_gap(rx_steady);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      res_ch.ready <= (rx_wait == 0);
    end
  end

  task automatic config_write(input logic [shl2_pkg::CFG_ADDR_W-1:0] addr,
                              input logic [shl2_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_mode_reg();
    logic [shl2_pkg::CFG_DATA_W-1:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_EVAL_MODE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== shl2_pkg::CFG_DATA_W'(mode_shadow)) begin
      $error("eval_mode expected %0d got %0d", mode_shadow, rd);
      mismatches++;
    end
  endtask

  // Waits until every word is taken and every result is in, then lets a load settle.
  task automatic wait_drained();
    do @(posedge clk); while (words_accepted != words_queued || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] mode, input int count);
    cmd_word_t w;
    real vx, vy, vz, len;
    int axis, sign;
    config_write(ADDR_EVAL_MODE, {(shl2_pkg::CFG_DATA_W-2)'($urandom), mode});
    mode_shadow = mode;
    verify_mode_reg();
    for (int n = 0; n < count; n++) begin
      w.kind       = ($urandom_range(0, 9) < 4) ? shl2_pkg::KIND_WRITE : shl2_pkg::KIND_EVAL;
      w.coef_index = ($urandom_range(0, 9) == 0) ? shl2_pkg::IDX_W'($urandom_range(9, 15))
                                                 : shl2_pkg::IDX_W'($urandom_range(0, 8));
      w.coef_red   = random_coef();
      w.coef_green = random_coef();
      w.coef_blue  = random_coef();
      case ($urandom_range(0, 9))
        0: begin
          axis = $urandom_range(0, 2);
          sign = $urandom_range(0, 1) ? -shl2_pkg::ONE_Q14 : shl2_pkg::ONE_Q14;
          w.dir_x = (axis == 0) ? shl2_pkg::DIR_W'(sign) : '0;
          w.dir_y = (axis == 1) ? shl2_pkg::DIR_W'(sign) : '0;
          w.dir_z = (axis == 2) ? shl2_pkg::DIR_W'(sign) : '0;
        end
        1, 2: begin
          // Non-unit directions over the whole field range.
          w.dir_x = shl2_pkg::DIR_W'($urandom);
          w.dir_y = shl2_pkg::DIR_W'($urandom);
          w.dir_z = shl2_pkg::DIR_W'($urandom);
        end
        default: begin
          vx  = $urandom_range(0, 20000) / 10000.0 - 1.0;
          vy  = $urandom_range(0, 20000) / 10000.0 - 1.0;
          vz  = $urandom_range(0, 20000) / 10000.0 - 1.0;
          len = $sqrt(vx * vx + vy * vy + vz * vz);
          if (len < 1.0e-3) begin
            vz  = 1.0;
            len = 1.0;
          end
          w.dir_x = shl2_pkg::DIR_W'($rtoi(vx / len * 16384.0));
          w.dir_y = shl2_pkg::DIR_W'($rtoi(vy / len * 16384.0));
          w.dir_z = shl2_pkg::DIR_W'($rtoi(vz / len * 16384.0));
        end
      endcase
      push_word(w);
    end
    wait_drained();
  endtask

  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.kind       = shl2_pkg::KIND_WRITE;
    cmd_ch.coef_index = '0;
    cmd_ch.coef_red   = '0;
    cmd_ch.coef_green = '0;
    cmd_ch.coef_blue  = '0;
    cmd_ch.dir_x      = '0;
    cmd_ch.dir_y      = '0;
    cmd_ch.dir_z      = '0;
    res_ch.ready      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The mode register comes out of reset as irradiance.
    verify_mode_reg();

    // A cleared store must give black.
    push_word(eval_word(shl2_pkg::ONE_Q14, 0, 0));
    push_word(load_word(0, 8388607, -8388608, 4096));
    push_word(load_word(1, 2048, -2048, 0));
    push_word(load_word(2, -1, 1, 8388607));
    push_word(load_word(3, 8388607, 8388607, -8388608));
    push_word(load_word(4, -8388608, 12288, 1));
    push_word(load_word(5, 4096, -4096, 40960));
    push_word(load_word(6, -409, 8388607, -8388608));
    push_word(load_word(7, 0, -1, 65536));
    push_word(load_word(8, 300000, -300000, 7));
    // Loads beyond the last basis index must leave the store alone.
    push_word(load_word(9, 8388607, 8388607, 8388607));
    push_word(load_word(15, -8388608, -8388608, -8388608));
    push_word(eval_word(shl2_pkg::ONE_Q14, 0, 0));
    push_word(eval_word(0, -shl2_pkg::ONE_Q14, 0));
    push_word(eval_word(0, 0, shl2_pkg::ONE_Q14));
    push_word(eval_word(0, 0, 0));
    push_word(eval_word(-shl2_pkg::ONE_Q14, -shl2_pkg::ONE_Q14, -shl2_pkg::ONE_Q14));
    push_word(eval_word(-32768, -32768, -32768));
    push_word(eval_word(32767, 32767, 32767));
    push_word(eval_word(32767, -32768, 0));
    wait_drained();

    run_phase(shl2_pkg::MODE_IRRADIANCE, 70);
    run_phase(shl2_pkg::MODE_RADIANCE, 64);
    run_phase(shl2_pkg::MODE_AMBIENT, 64);

    // A write to an unmapped register must not disturb the mode.
    config_write(ADDR_UNMAPPED, shl2_pkg::CFG_DATA_W'(shl2_pkg::MODE_RADIANCE));
    verify_mode_reg();

    run_phase(MODE_UNUSED, 64);
    run_phase(shl2_pkg::MODE_IRRADIANCE, 64);
    run_phase(shl2_pkg::MODE_RADIANCE, 64);
    run_phase(shl2_pkg::MODE_AMBIENT, 64);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sh_l2_radiance_irradiance_eval_unit.f
rtl/core/shl2_pkg.sv
rtl/core/shl2_if.sv
rtl/core/sh_l2_radiance_irradiance_eval_unit.sv
bench/tb_sh_l2_radiance_irradiance_eval_unit.sv
